[design/iad_pkg.sv]
`timescale 1ns / 1ps

package iad_pkg;

    localparam int NUM_CELLS     = 8;
    localparam int BITS_PER_CELL = 2;
    localparam int VALUE_W       = 16;
    localparam int BCD_DIGITS    = 5;
    localparam int BCD_W         = 4 * BCD_DIGITS;
    localparam int MAX_CHARS     = 16;
    localparam int CNT_W         = 5;

    localparam logic [1:0] MODE_BIN = 2'd0;
    localparam logic [1:0] MODE_OCT = 2'd1;
    localparam logic [1:0] MODE_DEC = 2'd2;
    localparam logic [1:0] MODE_HEX = 2'd3;

    localparam logic [1:0] SIZE_NIB  = 2'd0;
    localparam logic [1:0] SIZE_BYTE = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    localparam logic [1:0] REG_DIGIT_BASE  = 2'd0;
    localparam logic [1:0] REG_LETTER_BASE = 2'd1;

    localparam logic [7:0] ZERO_CODE       = 8'd48;
    localparam logic [7:0] LETTER_RESET    = 8'd65;

    // one conversion word as it travels down the cell row
    typedef struct packed {
        logic [VALUE_W-1:0] val;   // masked value, kept intact
        logic [VALUE_W-1:0] sh;    // bits still to be shifted into the BCD
        logic [BCD_W-1:0]   bcd;
        logic [1:0]         mode;
        logic [1:0]         size_sel;
        logic               supp;
        logic               fixed;
    } iad_word_t;

    typedef logic [MAX_CHARS-1:0][7:0] iad_chars_t;

    // one double-dabble step: add 3 to digits >= 5, then shift in a bit
    function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd,
                                                 input logic             bit_in);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int d = 0; d < BCD_DIGITS; d++) begin
            if (adj[4*d +: 4] >= 4'd5) begin
                adj[4*d +: 4] = adj[4*d +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], bit_in};
    endfunction

endpackage

[design/integer_to_ascii_digits.sv]
`timescale 1ns / 1ps

// Unsigned value to ASCII digit string converter.
// Input channel (in_valid / in_stall) takes one word per conversion: value, mode
// (binary, octal, decimal, hex), size_sel, suppress_zeros and fixed_zero.
// Output channel (out_valid / out_stall) returns one character per word, most
// significant digit first, with last set on the final character. An unsupported
// radix/size pair returns a single word with char_code 0 and bad_request set.
// Config port (cfg_we, cfg_index, cfg_data): index 0 digit base, index 1 letter
// base; write only while the converter is idle.
// Each accepted word passes through 8 double-dabble cells (2 bits each), then the
// output shifter. Throughput: one character per cycle while out_stall is low; a
// conversion is 1 to 16 characters, all sent through the single output
// shifter; the cell row takes a word every cycle until a word reaches its tail,
// then moves only as the shifter takes that word, so sustained input is one word
// per string, and the next string follows the previous last character with no gap.
// Reset clears all valid flags and the character count and restores the digit
// base to 48 and the letter base to 65. While out_stall is high the output word
// holds; the cell row keeps filling and then raises in_stall.

module integer_to_ascii_digits
    import iad_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] value,
    input  logic [1:0]  mode,
    input  logic [1:0]  size_sel,
    input  logic        suppress_zeros,
    input  logic        fixed_zero,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  char_code,
    output logic        last,
    output logic        bad_request,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic [7:0]       digit_base_reg;
    logic [7:0]       letter_base_reg;
    iad_word_t        head_word;
    iad_word_t        cell_word  [NUM_CELLS+1];
    logic             cell_valid [NUM_CELLS+1];
    logic             adv;
    logic             ser_ready;
    iad_chars_t       fmt_chars;
    logic [CNT_W-1:0] fmt_count;
    logic             fmt_bad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_base_reg  <= ZERO_CODE;
            letter_base_reg <= LETTER_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_DIGIT_BASE)
            begin
                digit_base_reg <= cfg_data;
            end
            else if (cfg_index == REG_LETTER_BASE)
            begin
                letter_base_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        head_word          = '0;
        head_word.mode     = mode;
        head_word.size_sel = size_sel;
        head_word.supp     = suppress_zeros;
        head_word.fixed    = fixed_zero;
        unique case (size_sel)
            SIZE_NIB:  head_word.val = {12'd0, value[3:0]};
            SIZE_BYTE: head_word.val = {8'd0, value[7:0]};
            default:   head_word.val = value;
        endcase
        head_word.sh = head_word.val;
    end

    // whole row moves together whenever the tail word can leave
    assign adv      = !cell_valid[NUM_CELLS] || ser_ready;
    assign in_stall = !adv;

    assign cell_word[0]  = head_word;
    assign cell_valid[0] = in_valid;

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        iad_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .adv        (adv),
            .prev_valid (cell_valid[i]),
            .prev_word  (cell_word[i]),
            .valid_reg  (cell_valid[i+1]),
            .word_reg   (cell_word[i+1])
        );
    end

    iad_format u_format (
        .word        (cell_word[NUM_CELLS]),
        .digit_base  (digit_base_reg),
        .letter_base (letter_base_reg),
        .chars       (fmt_chars),
        .count       (fmt_count),
        .bad         (fmt_bad)
    );

    iad_serializer u_serializer (
        .clk         (clk),
        .rst_n       (rst_n),
        .src_valid   (cell_valid[NUM_CELLS]),
        .src_chars   (fmt_chars),
        .src_count   (fmt_count),
        .src_bad     (fmt_bad),
        .ready       (ser_ready),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .char_code   (char_code),
        .last        (last),
        .bad_request (bad_request)
    );

endmodule

[design/iad_cell.sv]
`timescale 1ns / 1ps

module iad_cell
    import iad_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  logic      prev_valid,
    input  iad_word_t prev_word,
    output logic      valid_reg,
    output iad_word_t word_reg
);

    iad_word_t word_next;

    always_comb
    begin
        word_next = prev_word;
        for (int b = 0; b < BITS_PER_CELL; b++)
        begin
            word_next.bcd = dd_step(word_next.bcd, word_next.sh[VALUE_W-1]);
            word_next.sh  = {word_next.sh[VALUE_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            word_reg <= word_next;
        end
    end

endmodule

[design/iad_format.sv]
`timescale 1ns / 1ps

module iad_format
    import iad_pkg::*;
(
    input  iad_word_t        word,
    input  logic [7:0]       digit_base,
    input  logic [7:0]       letter_base,
    output iad_chars_t       chars,
    output logic [CNT_W-1:0] count,
    output logic             bad
);

    logic [7:0]         zb;
    logic [CNT_W-1:0]   len;
    logic [3:0]         dig [MAX_CHARS];
    logic [VALUE_W-1:0] aligned;
    logic [BCD_W-1:0]   bcd_al;

    always_comb
    begin
        zb      = word.fixed ? ZERO_CODE : digit_base;
        bad     = (word.size_sel == 2'd3)
               || (word.mode == MODE_OCT && word.size_sel != SIZE_BYTE)
               || (word.mode == MODE_DEC && word.size_sel == SIZE_NIB && !word.supp)
               || (word.mode == MODE_HEX && word.size_sel == SIZE_NIB);
        len     = '0;
        aligned = '0;
        bcd_al  = '0;
        for (int k = 0; k < MAX_CHARS; k++)
        begin
            dig[k] = 4'd0;
        end

        unique case (word.mode)
            MODE_BIN:
            begin
                unique case (word.size_sel)
                    SIZE_NIB:  len = 5'd4;
                    SIZE_BYTE: len = 5'd8;
                    default:   len = 5'd16;
                endcase
                aligned = word.val << (5'd16 - len);
                for (int k = 0; k < MAX_CHARS; k++)
                begin
                    dig[k] = {3'b000, aligned[VALUE_W-1-k]};
                end
            end
            MODE_OCT:
            begin
                len    = 5'd3;
                dig[0] = {2'b00, word.val[7:6]};
                dig[1] = {1'b0, word.val[5:3]};
                dig[2] = {1'b0, word.val[2:0]};
            end
            MODE_DEC:
            begin
                if (word.supp)
                begin
                    // value is masked, so the significant length never exceeds the size
                    priority if (word.bcd[19:16] != 4'd0) len = 5'd5;
                    else if (word.bcd[15:12] != 4'd0)     len = 5'd4;
                    else if (word.bcd[11:8] != 4'd0)      len = 5'd3;
                    else if (word.bcd[7:4] != 4'd0)       len = 5'd2;
                    else                                  len = 5'd1;
                end
                else
                begin
                    unique case (word.size_sel)
                        SIZE_NIB:  len = 5'd2;
                        SIZE_BYTE: len = 5'd3;
                        default:   len = 5'd5;
                    endcase
                end
                bcd_al = word.bcd << {3'd5 - len[2:0], 2'b00};
                for (int k = 0; k < BCD_DIGITS; k++)
                begin
                    dig[k] = bcd_al[BCD_W-1-4*k -: 4];
                end
            end
            default:
            begin
                len     = (word.size_sel == SIZE_BYTE) ? 5'd2 : 5'd4;
                aligned = word.val << {3'd4 - len[2:0], 2'b00};
                for (int k = 0; k < 4; k++)
                begin
                    dig[k] = aligned[VALUE_W-1-4*k -: 4];
                end
            end
        endcase

        for (int k = 0; k < MAX_CHARS; k++)
        begin
            if (dig[k] < 4'd10)
            begin
                chars[k] = zb + {4'b0000, dig[k]};
            end
            else
            begin
                chars[k] = letter_base + ({4'b0000, dig[k]} - 8'd10);
            end
        end

        if (bad)
        begin
            chars[0] = 8'd0;
            count    = 5'd1;
        end
        else
        begin
            count = len;
        end
    end

endmodule

[design/iad_serializer.sv]
`timescale 1ns / 1ps

module iad_serializer
    import iad_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             src_valid,
    input  iad_chars_t       src_chars,
    input  logic [CNT_W-1:0] src_count,
    input  logic             src_bad,
    output logic             ready,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       char_code,
    output logic             last,
    output logic             bad_request
);

    iad_chars_t       chars_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             bad_reg;
    logic             take;
    logic             load;

    assign out_valid   = (cnt_reg != '0);
    assign take        = out_valid && !out_stall;
    // free now, or the final character of the current word leaves this cycle
    assign ready       = (cnt_reg == '0) || (cnt_reg == 5'd1 && !out_stall);
    assign load        = src_valid && ready;
    assign char_code   = chars_reg[0];
    assign last        = (cnt_reg == 5'd1);
    assign bad_request = bad_reg;

    always_comb
    begin
        priority if (load)
        begin
            cnt_next = src_count;
        end
        else if (take)
        begin
            cnt_next = cnt_reg - 5'd1;
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            chars_reg <= src_chars;
            bad_reg   <= src_bad;
        end
        else if (take)
        begin
            for (int k = 0; k < MAX_CHARS - 1; k++)
            begin
                chars_reg[k] <= chars_reg[k+1];
            end
        end
    end

endmodule

[sim/iad_char_checker.sv]
`timescale 1ns / 1ps

module iad_char_checker
    import iad_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [15:0] value,
    input  logic [1:0]  mode,
    input  logic [1:0]  size_sel,
    input  logic        suppress_zeros,
    input  logic        fixed_zero,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  char_code,
    input  logic        last,
    input  logic        bad_request,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        end_of_test,
    output int          fail_count,
    output int          pending,
    output int          words_seen,
    output int          chars_seen,
    output int          rejects_seen
);

    typedef struct packed {
        logic [7:0] code;
        logic       last;
        logic       bad;
    } char_exp_t;

    char_exp_t expected_chars[$];

    logic [7:0] digit_base_q;
    logic [7:0] letter_base_q;

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function automatic logic [7:0] char_for_digit(input logic [3:0] d, input logic [7:0] zb);
        if (d < 4'd10)
        begin
            return zb + {4'd0, d};
        end
        return letter_base_q + ({4'd0, d} - 8'd10);
    endfunction

    task automatic predict_conversion(input logic [15:0] val, input logic [1:0] md,
                                      input logic [1:0] sz, input logic supp,
                                      input logic fix);
        logic [15:0] v;
        logic [7:0]  zb;
        logic [3:0]  dig [0:15];
        int          nd;
        int          first;
        int          t;
        bit          bad;
        char_exp_t   e;
        zb    = fix ? ZERO_CODE : digit_base_q;
        bad   = 1'b0;
        nd    = 0;
        first = 0;
        case (sz)
            SIZE_NIB:  v = val & 16'h000F;
            SIZE_BYTE: v = val & 16'h00FF;
            default:   v = val;
        endcase
        if (sz != SIZE_NIB && sz != SIZE_BYTE && sz != SIZE_WORD)
        begin
            bad = 1'b1;
        end
        else
        begin
            case (md)
                MODE_BIN:
                begin
                    nd = (sz == SIZE_NIB) ? 4 : (sz == SIZE_BYTE) ? 8 : 16;
                    for (int i = 0; i < nd; i++)
                    begin
                        dig[nd-1-i] = {3'd0, v[i]};
                    end
                end
                MODE_OCT:
                begin
                    if (sz != SIZE_BYTE)
                    begin
                        bad = 1'b1;
                    end
                    else
                    begin
                        nd     = 3;
                        dig[0] = {2'd0, v[7:6]};
                        dig[1] = {1'b0, v[5:3]};
                        dig[2] = {1'b0, v[2:0]};
                    end
                end
                MODE_DEC:
                begin
                    if (sz == SIZE_NIB && !supp)
                    begin
                        bad = 1'b1;
                    end
                    else
                    begin
                        t  = v;
                        nd = (sz == SIZE_NIB) ? 2 : (sz == SIZE_BYTE) ? 3 : 5;
                        for (int i = 0; i < nd; i++)
                        begin
                            dig[nd-1-i] = 4'(t % 10);
                            t = t / 10;
                        end
                        // drop leading zeros but always keep one digit
                        if (supp)
                        begin
                            while (first + 1 < nd && dig[first] == 4'd0)
                            begin
                                first++;
                            end
                        end
                    end
                end
                MODE_HEX:
                begin
                    if (sz == SIZE_NIB)
                    begin
                        bad = 1'b1;
                    end
                    else
                    begin
                        nd = (sz == SIZE_BYTE) ? 2 : 4;
                        for (int i = 0; i < nd; i++)
                        begin
                            dig[nd-1-i] = v[4*i +: 4];
                        end
                    end
                end
            endcase
        end
        if (bad)
        begin
            e.code = 8'd0;
            e.last = 1'b1;
            e.bad  = 1'b1;
            expected_chars.push_back(e);
            rejects_seen++;
        end
        else
        begin
            for (int i = first; i < nd; i++)
            begin
                e.code = char_for_digit(dig[i], zb);
                e.last = (i == nd - 1);
                e.bad  = 1'b0;
                expected_chars.push_back(e);
            end
        end
    endtask

    initial
    begin
        fail_count   = 0;
        pending      = 0;
        words_seen   = 0;
        chars_seen   = 0;
        rejects_seen = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        char_exp_t e;
        if (!rst_n)
        begin
            digit_base_q  <= ZERO_CODE;
            letter_base_q <= LETTER_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_DIGIT_BASE)
                begin
                    digit_base_q <= cfg_data;
                end
                else if (cfg_index == REG_LETTER_BASE)
                begin
                    letter_base_q <= cfg_data;
                end
            end
            if (in_valid && !in_stall)
            begin
                words_seen++;
                predict_conversion(value, mode, size_sel, suppress_zeros, fixed_zero);
            end
            if (out_valid && !out_stall)
            begin
                chars_seen++;
                if (expected_chars.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected word code=%0d last=%0b bad=%0b",
                                              char_code, last, bad_request));
                end
                else
                begin
                    e = expected_chars.pop_front();
                    if (char_code !== e.code)
                    begin
                        report_mismatch($sformatf("char_code %0d, expected %0d",
                                                  char_code, e.code));
                    end
                    if (last !== e.last)
                    begin
                        report_mismatch($sformatf("last %0b, expected %0b", last, e.last));
                    end
                    if (bad_request !== e.bad)
                    begin
                        report_mismatch($sformatf("bad_request %0b, expected %0b",
                                                  bad_request, e.bad));
                    end
                end
            end
            if (end_of_test && expected_chars.size() != 0)
            begin
                report_mismatch($sformatf("%0d expected words never arrived",
                                          expected_chars.size()));
                expected_chars.delete();
            end
            pending = expected_chars.size();
        end
    end

endmodule

[sim/tb_integer_to_ascii_digits.sv]
`timescale 1ns / 1ps

module tb_integer_to_ascii_digits;
    import iad_pkg::*;

    localparam logic [1:0] REG_SPARE_A = 2'd2;
    localparam logic [1:0] REG_SPARE_B = 2'd3;
    localparam logic [1:0] SIZE_NONE   = 2'd3;
    localparam int         WORDS_PER_PHASE = 70;
    localparam int         NUM_PHASES      = 6;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] value;
    logic [1:0]  mode;
    logic [1:0]  size_sel;
    logic        suppress_zeros;
    logic        fixed_zero;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  char_code;
    logic        last;
    logic        bad_request;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        end_of_test;

    int fail_count;
    int pending;
    int words_seen;
    int chars_seen;
    int rejects_seen;
    int send_idle_pct;
    int recv_stall_pct;

    integer_to_ascii_digits dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .value          (value),
        .mode           (mode),
        .size_sel       (size_sel),
        .suppress_zeros (suppress_zeros),
        .fixed_zero     (fixed_zero),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .char_code      (char_code),
        .last           (last),
        .bad_request    (bad_request),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    iad_char_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .value          (value),
        .mode           (mode),
        .size_sel       (size_sel),
        .suppress_zeros (suppress_zeros),
        .fixed_zero     (fixed_zero),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .char_code      (char_code),
        .last           (last),
        .bad_request    (bad_request),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .end_of_test    (end_of_test),
        .fail_count     (fail_count),
        .pending        (pending),
        .words_seen     (words_seen),
        .chars_seen     (chars_seen),
        .rejects_seen   (rejects_seen)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // called at a rising edge; returns at the edge where the word is taken
    task automatic push_word(input logic [15:0] v, input logic [1:0] m, input logic [1:0] s,
                             input logic sup, input logic fx);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid       <= 1'b1;
        value          <= v;
        mode           <= m;
        size_sel       <= s;
        suppress_zeros <= sup;
        fixed_zero     <= fx;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
    endtask

    task automatic push_random_word;
        logic [15:0] v;
        logic [1:0]  m;
        logic [1:0]  s;
        int          pick;
        m    = 2'($urandom_range(0, 3));
        s    = ($urandom_range(0, 19) == 0) ? SIZE_NONE : 2'($urandom_range(0, 2));
        pick = $urandom_range(0, 3);
        // small values put zeros in the leading digits
        if (pick == 0)
        begin
            v = 16'($urandom_range(0, 20));
        end
        else if (pick == 1)
        begin
            v = {4'($urandom_range(0, 15)), 12'($urandom_range(0, 4095))} ^ 16'($urandom);
        end
        else
        begin
            v = 16'($urandom);
        end
        push_word(v, m, s, 1'($urandom_range(0, 1)), ($urandom_range(0, 3) == 0));
    endtask

    task automatic wait_drained;
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (12) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    initial
    begin
        logic [7:0] digit_sel [NUM_PHASES];
        logic [7:0] letter_sel [NUM_PHASES];
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        value          = 16'd0;
        mode           = MODE_BIN;
        size_sel       = SIZE_NIB;
        suppress_zeros = 1'b0;
        fixed_zero     = 1'b0;
        out_stall      = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_DIGIT_BASE;
        cfg_data       = 8'd0;
        end_of_test    = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        digit_sel  = '{8'd48, 8'd0,   8'd255, 8'($urandom), 8'd250, 8'd48};
        letter_sel = '{8'd97, 8'd0,   8'd255, 8'($urandom), 8'd253, 8'd65};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words at reset bases
        push_word(16'h0000, MODE_BIN, SIZE_NIB,  1'b0, 1'b0);
        push_word(16'hFFF3, MODE_BIN, SIZE_NIB,  1'b1, 1'b0);
        push_word(16'hFFFF, MODE_BIN, SIZE_BYTE, 1'b0, 1'b0);
        push_word(16'hA5C3, MODE_BIN, SIZE_WORD, 1'b0, 1'b1);
        push_word(16'h00FF, MODE_OCT, SIZE_BYTE, 1'b0, 1'b0);
        push_word(16'h1200, MODE_OCT, SIZE_BYTE, 1'b1, 1'b1);
        push_word(16'h0007, MODE_OCT, SIZE_NIB,  1'b0, 1'b0);
        push_word(16'h1234, MODE_OCT, SIZE_WORD, 1'b0, 1'b0);
        push_word(16'h00FF, MODE_DEC, SIZE_BYTE, 1'b0, 1'b0);
        push_word(16'h0000, MODE_DEC, SIZE_BYTE, 1'b0, 1'b0);
        push_word(16'hFFFF, MODE_DEC, SIZE_WORD, 1'b0, 1'b0);
        push_word(16'd10000, MODE_DEC, SIZE_WORD, 1'b1, 1'b0);
        push_word(16'h0000, MODE_DEC, SIZE_WORD, 1'b1, 1'b0);
        push_word(16'h0064, MODE_DEC, SIZE_BYTE, 1'b1, 1'b1);
        push_word(16'h000F, MODE_DEC, SIZE_NIB,  1'b1, 1'b0);
        push_word(16'h0003, MODE_DEC, SIZE_NIB,  1'b1, 1'b0);
        push_word(16'h0009, MODE_DEC, SIZE_NIB,  1'b0, 1'b0);
        push_word(16'h00A5, MODE_HEX, SIZE_BYTE, 1'b0, 1'b0);
        push_word(16'hFFFF, MODE_HEX, SIZE_WORD, 1'b1, 1'b1);
        push_word(16'h09AF, MODE_HEX, SIZE_WORD, 1'b0, 1'b0);
        push_word(16'h000C, MODE_HEX, SIZE_NIB,  1'b0, 1'b0);
        push_word(16'hFFFF, MODE_BIN, SIZE_NONE, 1'b1, 1'b1);
        push_word(16'h0000, MODE_DEC, SIZE_NONE, 1'b0, 1'b0);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained();
            write_reg(REG_DIGIT_BASE, digit_sel[p]);
            write_reg(REG_LETTER_BASE, letter_sel[p]);
            // unused indexes must leave both bases alone
            if (p == 3)
            begin
                write_reg(REG_SPARE_A, 8'($urandom));
                write_reg(REG_SPARE_B, 8'($urandom));
            end
            cfg_we <= 1'b0;
            case (p % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            repeat (WORDS_PER_PHASE) push_random_word();
        end

        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (30) @(negedge clk);
        @(posedge clk);
        end_of_test <= 1'b1;
        @(posedge clk);
        end_of_test <= 1'b0;
        @(negedge clk);

        $display("Converted %0d words into %0d characters, %0d of them rejected requests,",
                 words_seen, chars_seen, rejects_seen);
        $display("over all radix/size pairs, %0d base settings, gaps and stalls on both sides.",
                 NUM_PHASES + 1);
        if (fail_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout waiting for the converter");
        $display("*** FAILED ***");
        $finish;
    end

endmodule
